// ===== hdl/fpfir_pkg.sv =====
// Shared constants, codes and types of the fixed-point FIR convolution block.
package fpfir_pkg;

  localparam int MAX_TAPS_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int FRAC_W       = 5;
  localparam int NTAPS_W      = 5;
  localparam int IDX_W        = 4;
  localparam int S_TDATA_W    = 40;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS  = 1'd1;

  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [FRAC_W-1:0]  FRAC_BITS_RST = 5'd15;
  localparam logic [NTAPS_W-1:0] NUM_TAPS_RST  = 5'd16;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hdl/fpfir_cell.sv =====
// One tap cell: coefficient, sample stage, scaled product and partial sum.
module fpfir_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fpfir_pkg::cell_ctrl_t              ctrl_i,
  input  logic [fpfir_pkg::FRAC_W-1:0]       frac_bits_i,
  input  logic                               tap_en_i,
  input  logic                               coef_we_i,
  input  logic [fpfir_pkg::DATA_W-1:0]       coef_i,
  input  logic [fpfir_pkg::DATA_W-1:0]       sample_i,
  output logic [fpfir_pkg::DATA_W-1:0]       sample_o,
  input  logic [fpfir_pkg::DATA_W-1:0]       sum_i,
  output logic [fpfir_pkg::DATA_W-1:0]       sum_o
);

  logic        [fpfir_pkg::DATA_W-1:0] coef_q;
  logic        [fpfir_pkg::DATA_W-1:0] sample_q;
  logic signed [fpfir_pkg::PROD_W-1:0] prod_q;
  logic        [fpfir_pkg::DATA_W-1:0] term_q;
  logic        [fpfir_pkg::DATA_W-1:0] sum_q;

  logic signed [fpfir_pkg::PROD_W-1:0] prod_d;
  logic signed [fpfir_pkg::PROD_W-1:0] bias;
  logic signed [fpfir_pkg::PROD_W-1:0] scaled;
  logic        [fpfir_pkg::DATA_W-1:0] term_d;
  logic        [fpfir_pkg::DATA_W-1:0] sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      sample_q <= '0;
    end else begin
      if (coef_we_i) begin
        coef_q <= coef_i;
      end
      if (ctrl_i.clear) begin
        sample_q <= '0;
      end else if (ctrl_i.shift) begin
        sample_q <= sample_i;
      end
    end
  end

  assign prod_d = $signed(sample_q) * $signed(coef_q);

  // divide by 2^frac with truncation toward zero
  always_comb begin
    if (prod_q[fpfir_pkg::PROD_W-1]) begin
      bias = (fpfir_pkg::PROD_W'(1) <<< frac_bits_i) - fpfir_pkg::PROD_W'(1);
    end else begin
      bias = '0;
    end
    scaled = (prod_q + bias) >>> frac_bits_i;
    term_d = scaled[fpfir_pkg::DATA_W-1:0];
    sum_d  = sum_i + (tap_en_i ? term_q : '0);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    term_q <= term_d;
    sum_q  <= sum_d;
  end

  assign sample_o = sample_q;
  assign sum_o    = sum_q;

endmodule

// ===== hdl/fixed_point_fir_convolution.sv =====
// A sample transfer starts a computation; its output appears on m_axis once the partial
// sum has rippled one cell per cycle through the cell chain and m_axis is free. No new
// item is accepted on s_axis until then; a coefficient write is taken only while idle.
// A last sample adds taps_eff-1 tail outputs (num_taps clamped to 1..MAX_TAPS).
// Reset (async, active low): coefficients and history zero, frac_bits 15,
// num_taps 16, no output pending.
module fixed_point_fir_convolution #(
  parameter int MAX_TAPS = fpfir_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [3:0] tap_index, [35:4] value, [39:36] zero
  input  logic [fpfir_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] mode
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] out_value
  output logic [fpfir_pkg::DATA_W-1:0]        m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpfir_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fpfir_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int LAT = MAX_TAPS + 2;
  localparam int CW  = $clog2(LAT + 1);
  localparam int TW  = $clog2(MAX_TAPS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;

  logic                              state_q;
  logic [CW-1:0]                     cnt_q;
  logic [TW-1:0]                     tail_q;
  logic                              flush_q;
  logic [fpfir_pkg::FRAC_W-1:0]      frac_bits_q;
  logic [fpfir_pkg::NTAPS_W-1:0]     num_taps_q;
  logic                              m_valid_q;
  logic [fpfir_pkg::DATA_W-1:0]      m_data_q;
  logic                              m_last_q;

  logic                              s_xfer;
  logic                              is_sample;
  logic                              is_coef;
  logic [fpfir_pkg::IDX_W-1:0]       tap_index;
  logic [fpfir_pkg::DATA_W-1:0]      in_value;
  logic [TW-1:0]                     taps_eff;
  logic                              out_free;
  logic                              done;
  logic                              tail_more;
  fpfir_pkg::cell_ctrl_t             ctrl;
  logic [fpfir_pkg::DATA_W-1:0]      shift_in;

  logic [fpfir_pkg::DATA_W-1:0]      samp [MAX_TAPS];
  logic [fpfir_pkg::DATA_W-1:0]      sums [MAX_TAPS+1];

  assign tap_index = s_axis_tdata_i[fpfir_pkg::IDX_W-1:0];
  assign in_value  = s_axis_tdata_i[fpfir_pkg::IDX_W +: fpfir_pkg::DATA_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_sample       = s_xfer && (s_axis_tuser_i == fpfir_pkg::MODE_SAMPLE);
  assign is_coef         = s_xfer && (s_axis_tuser_i == fpfir_pkg::MODE_COEF);

  always_comb begin
    if (num_taps_q == '0) begin
      taps_eff = TW'(1);
    end else if (int'(num_taps_q) > MAX_TAPS) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(num_taps_q);
    end
  end

  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign done       = (state_q == S_CALC) && (cnt_q == '0) && out_free;
  assign tail_more  = flush_q && (tail_q != '0);
  assign ctrl.shift = is_sample || (done && tail_more);
  assign ctrl.clear = done && flush_q && (tail_q == '0);
  assign shift_in   = (state_q == S_IDLE) ? in_value : '0;

  assign sums[MAX_TAPS] = '0;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    fpfir_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .frac_bits_i (frac_bits_q),
      .tap_en_i    ((j == 0) || (j < int'(num_taps_q))),
      .coef_we_i   (is_coef && (int'(tap_index) == j)),
      .coef_i      (in_value),
      .sample_i    ((j == 0) ? shift_in : samp[(j == 0) ? 0 : j-1]),
      .sample_o    (samp[j]),
      .sum_i       (sums[j+1]),
      .sum_o       (sums[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q <= fpfir_pkg::FRAC_BITS_RST;
      num_taps_q  <= fpfir_pkg::NUM_TAPS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fpfir_pkg::REG_FRAC_BITS: frac_bits_q <= cfg_data_i;
        fpfir_pkg::REG_NUM_TAPS:  num_taps_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      tail_q    <= '0;
      flush_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && !done) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (is_sample) begin
            state_q <= S_CALC;
            cnt_q   <= CW'(LAT);
            flush_q <= s_axis_tlast_i;
            tail_q  <= s_axis_tlast_i ? taps_eff - TW'(1) : '0;
          end
        end
        S_CALC: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - CW'(1);
          end else if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= sums[0];
            m_last_q  <= flush_q && (tail_q == '0);
            if (tail_more) begin
              tail_q <= tail_q - TW'(1);
              cnt_q  <= CW'(LAT);
            end else begin
              state_q <= S_IDLE;
              flush_q <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  a_sample_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_sample |=> (state_q == S_CALC) && (cnt_q == CW'(LAT)))
    else $error("sample transfer did not start a computation");

  a_coef_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_coef |=> (state_q == S_IDLE) && !$rose(m_valid_q))
    else $error("coefficient write produced activity");

  a_tail_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q != '0) |-> flush_q && (state_q == S_CALC))
    else $error("tail count outside a flush");

  a_history_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (samp[0] == '0) && m_valid_q && m_last_q)
    else $error("history not cleared after final output");

endmodule

// ===== verif/fpfir_checker.sv =====
// Checker for the FIR convolution block: tracks coefficients, history and settings, compares outputs.
module fpfir_checker #(
  parameter int MAX_TAPS = fpfir_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_valid_i,
  input  logic                                s_ready_i,
  // [3:0] tap_index, [35:4] value, [39:36] zero
  input  logic [fpfir_pkg::S_TDATA_W-1:0]     s_data_i,
  // [0] mode
  input  logic                                s_user_i,
  input  logic                                s_last_i,
  input  logic                                m_valid_i,
  input  logic                                m_ready_i,
  // [31:0] out_value
  input  logic [fpfir_pkg::DATA_W-1:0]        m_data_i,
  input  logic                                m_last_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [fpfir_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fpfir_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                  mismatch_count_o,
  output int                                  pending_o,
  output int                                  results_o
);

  typedef struct packed {
    logic [fpfir_pkg::DATA_W-1:0] value;
    logic                         last;
  } fir_out_t;

  logic [fpfir_pkg::DATA_W-1:0]  coef_q [MAX_TAPS];
  logic [fpfir_pkg::DATA_W-1:0]  hist_q [MAX_TAPS-1];
  logic [fpfir_pkg::FRAC_W-1:0]  frac_q;
  logic [fpfir_pkg::NTAPS_W-1:0] taps_q;
  fir_out_t                      expected_outputs [$];

  task automatic report_mismatch(string what);
    $display("[%0t] ERROR: %s", $time, what);
    mismatch_count_o++;
  endtask

  function automatic logic [fpfir_pkg::DATA_W-1:0] scaled_mul(
    logic [fpfir_pkg::DATA_W-1:0] a, logic [fpfir_pkg::DATA_W-1:0] b);
    longint prod;
    longint quot;
    prod = longint'($signed(a)) * longint'($signed(b));
    // signed division truncates toward zero
    quot = prod / (longint'(1) << frac_q);
    return quot[fpfir_pkg::DATA_W-1:0];
  endfunction

  function automatic logic [fpfir_pkg::DATA_W-1:0] fir_output_at(
    logic [fpfir_pkg::DATA_W-1:0] cur, int taps);
    logic [fpfir_pkg::DATA_W-1:0] acc;
    acc = scaled_mul(cur, coef_q[0]);
    for (int j = 1; j < taps; j++) begin
      acc += scaled_mul(hist_q[j-1], coef_q[j]);
    end
    return acc;
  endfunction

  task automatic shift_history(logic [fpfir_pkg::DATA_W-1:0] s);
    for (int i = MAX_TAPS - 2; i > 0; i--) begin
      hist_q[i] = hist_q[i-1];
    end
    hist_q[0] = s;
  endtask

  task automatic predict_sample(logic [fpfir_pkg::DATA_W-1:0] x, logic last);
    int taps;
    fir_out_t item;
    taps = int'(taps_q);
    if (taps < 1) taps = 1;
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    item.value = fir_output_at(x, taps);
    item.last  = last && (taps == 1);
    expected_outputs.push_back(item);
    shift_history(x);
    if (last) begin
      // tail: zeros shifted in after the final sample
      for (int t = 1; t < taps; t++) begin
        item.value = fir_output_at('0, taps);
        item.last  = (t == taps - 1);
        expected_outputs.push_back(item);
        shift_history('0);
      end
      for (int i = 0; i < MAX_TAPS - 1; i++) hist_q[i] = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fir_out_t want;
    if (!rst_ni) begin
      frac_q = fpfir_pkg::FRAC_BITS_RST;
      taps_q = fpfir_pkg::NUM_TAPS_RST;
      for (int i = 0; i < MAX_TAPS; i++) coef_q[i] = '0;
      for (int i = 0; i < MAX_TAPS - 1; i++) hist_q[i] = '0;
      expected_outputs.delete();
      mismatch_count_o = 0;
      pending_o = 0;
      results_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        results_o++;
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("output transfer %h with nothing expected", m_data_i));
        end else begin
          want = expected_outputs.pop_front();
          if (m_data_i !== want.value) begin
            report_mismatch($sformatf("out_value %h, expected %h", m_data_i, want.value));
          end
          if (m_last_i !== want.last) begin
            report_mismatch($sformatf("last_output %b, expected %b (out_value %h)",
                                      m_last_i, want.last, want.value));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fpfir_pkg::REG_FRAC_BITS: frac_q = cfg_data_i;
          fpfir_pkg::REG_NUM_TAPS:  taps_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i == fpfir_pkg::MODE_COEF) begin
          if (int'(s_data_i[3:0]) < MAX_TAPS) coef_q[s_data_i[3:0]] = s_data_i[35:4];
        end else begin
          predict_sample(s_data_i[35:4], s_last_i);
        end
      end
      pending_o = expected_outputs.size();
    end
  end

endmodule

// ===== verif/tb_fixed_point_fir_convolution.sv =====
// Testbench top for fixed_point_fir_convolution: clock, reset, stimulus and verdict.
module tb_fixed_point_fir_convolution;

  localparam int MAX_TAPS      = fpfir_pkg::MAX_TAPS_DEF;
  localparam int SETTLE_CYCLES = MAX_TAPS + 3 + 4;
  localparam int RX_HOLD       = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              s_axis_tvalid_i;
  logic                              s_axis_tready_o;
  logic [fpfir_pkg::S_TDATA_W-1:0]   s_axis_tdata_i;
  logic                              s_axis_tuser_i;
  logic                              s_axis_tlast_i;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i;
  logic [fpfir_pkg::DATA_W-1:0]      m_axis_tdata_o;
  logic                              m_axis_tlast_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [fpfir_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [fpfir_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  int   mismatches;
  int   pending;
  int   outputs_seen;
  int   cycle_count = 0;
  int   n_items = 0;
  int   n_samples = 0;
  int   n_settings = 0;
  logic steady = 1'b0;
  logic rx_hold_req = 1'b0;

  fixed_point_fir_convolution #(.MAX_TAPS(MAX_TAPS)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  fpfir_checker #(.MAX_TAPS(MAX_TAPS)) u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o), .s_data_i(s_axis_tdata_i),
    .s_user_i(s_axis_tuser_i), .s_last_i(s_axis_tlast_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i), .m_data_i(m_axis_tdata_o),
    .m_last_i(m_axis_tlast_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatches), .pending_o(pending), .results_o(outputs_seen)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d outputs still expected", cycle_count, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: random back-pressure plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
      end
      m_axis_tready_i <= steady || ($urandom_range(99) >= 20);
    end
  end

  function automatic logic [fpfir_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(131071) - 65536;
    endcase
  endfunction

  task automatic send_item(logic mode, logic [fpfir_pkg::IDX_W-1:0] idx,
                           logic [fpfir_pkg::DATA_W-1:0] val, logic last);
    while (!steady && $urandom_range(99) < 20) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {4'b0, val, idx};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    n_items++;
    if (mode == fpfir_pkg::MODE_SAMPLE) n_samples++;
  endtask

  task automatic drain_outputs();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [fpfir_pkg::CFG_IDX_W-1:0] idx,
                           logic [fpfir_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_filter(logic [fpfir_pkg::CFG_DATA_W-1:0] frac,
                            logic [fpfir_pkg::CFG_DATA_W-1:0] taps);
    drain_outputs();
    write_reg(fpfir_pkg::REG_FRAC_BITS, frac);
    write_reg(fpfir_pkg::REG_NUM_TAPS, taps);
    n_settings++;
  endtask

  initial begin
    int   seq_len;
    int   phase_end;
    logic hold_done;
    logic [fpfir_pkg::CFG_DATA_W-1:0] frac_plan [4];
    logic [fpfir_pkg::CFG_DATA_W-1:0] taps_plan [4];
    frac_plan = '{5'd1, 5'd31, 5'd0, 5'd15};
    taps_plan = '{5'd16, 5'd2, 5'd31, 5'd1};
    hold_done       = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = fpfir_pkg::MODE_COEF;
    s_axis_tlast_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = fpfir_pkg::REG_FRAC_BITS;
    cfg_data_i      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: 16 taps, Q15, extreme coefficients; coef write carrying last
    send_item(fpfir_pkg::MODE_COEF, 4'd0,  32'h7FFF_FFFF, 1'b0);
    send_item(fpfir_pkg::MODE_COEF, 4'd15, 32'h8000_0000, 1'b0);
    send_item(fpfir_pkg::MODE_COEF, 4'd1,  32'h0000_8000, 1'b0);
    send_item(fpfir_pkg::MODE_COEF, 4'd7,  32'hFFFF_8000, 1'b1);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0,  32'h7FFF_FFFF, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd15, 32'h8000_0000, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0,  32'h0000_0000, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd9,  32'hFFFF_FFFF, 1'b1);
    // no scaling, single tap: one output flagged last
    set_filter(5'd0, 5'd1);
    send_item(fpfir_pkg::MODE_COEF, 4'd0, 32'h8000_0000, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h8000_0000, 1'b1);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h7FFF_FFFF, 1'b0);
    // zero tap count acts as one
    set_filter(5'd31, 5'd0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h8000_0000, 1'b1);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h1234_5678, 1'b1);
    // tap count raised mid-sequence, then above the table size
    set_filter(5'd1, 5'd4);
    send_item(fpfir_pkg::MODE_COEF, 4'd1, 32'h0000_0003, 1'b0);
    send_item(fpfir_pkg::MODE_COEF, 4'd2, 32'hFFFF_FFFE, 1'b0);
    send_item(fpfir_pkg::MODE_COEF, 4'd3, 32'h4000_0000, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h0000_0101, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'hFFFF_0000, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h0001_0000, 1'b0);
    set_filter(5'd15, 5'd31);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'h0000_7FFF, 1'b0);
    send_item(fpfir_pkg::MODE_SAMPLE, 4'd0, 32'hFFFF_8001, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        set_filter(frac_plan[ph], taps_plan[ph]);
      end else begin
        set_filter(5'($urandom_range(31)), 5'($urandom_range(1, 6)));
      end
      steady = (ph == 3);
      phase_end = n_items + 48;
      while (n_items < phase_end) begin
        case ($urandom_range(9))
          0: send_item(fpfir_pkg::MODE_COEF, 4'($urandom_range(15)), pick_value(),
                       1'($urandom_range(1)));
          1: send_item(fpfir_pkg::MODE_SAMPLE, 4'($urandom_range(15)), pick_value(),
                       1'($urandom_range(1)));
          2: drain_outputs();
          default: begin
            repeat ($urandom_range(2)) begin
              send_item(fpfir_pkg::MODE_COEF, 4'($urandom_range(15)), pick_value(),
                        1'($urandom_range(1)));
            end
            seq_len = $urandom_range(1, 6);
            for (int i = 0; i < seq_len; i++) begin
              send_item(fpfir_pkg::MODE_SAMPLE, 4'($urandom_range(15)), pick_value(),
                        (i == seq_len - 1) && ($urandom_range(9) != 0));
            end
          end
        endcase
        if (ph == 4 && !hold_done && n_items >= phase_end - 30) begin
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end
      end
    end
    steady = 1'b0;

    drain_outputs();
    repeat (2 * (MAX_TAPS + 3)) @(negedge clk_i);
    $display("Covered %0d input transfers (%0d samples) over %0d filter settings,",
             n_items, n_samples, n_settings + 1);
    $display("checked %0d output transfers, one %0d-cycle output stall included.",
             outputs_seen, RX_HOLD);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fpfir_pkg.sv
hdl/fpfir_cell.sv
hdl/fixed_point_fir_convolution.sv
verif/fpfir_checker.sv
verif/tb_fixed_point_fir_convolution.sv
